### rtl/acep_pkg.sv
// ----------------------------------------------------------------------------
// acep_pkg
// Types and constants shared by the escape sequence parser modules.
// ----------------------------------------------------------------------------
package acep_pkg;

    localparam int unsigned RGB_W   = 24;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // parse phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ESC        = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BRACKET    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DIGIT      = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BACKGROUND = 3'd4;

    // pending color codes: 0..5 are table colors
    localparam logic [CODE_W-1:0] CODE_RESET = 3'd6;
    localparam logic [CODE_W-1:0] CODE_NONE  = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 1'd1;

    localparam logic [RGB_W-1:0] DEFAULT_FG_RESET = 24'hFFFFFF;
    localparam logic [RGB_W-1:0] DEFAULT_BG_RESET = 24'h000000;

    // characters of interest
    localparam logic [BYTE_W-1:0] CH_ESC     = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_UPPER_J = 8'h4A;
    localparam logic [BYTE_W-1:0] CH_LOWER_M = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_0       = 8'h30;
    localparam logic [BYTE_W-1:0] CH_2       = 8'h32;
    localparam logic [BYTE_W-1:0] CH_3       = 8'h33;
    localparam logic [BYTE_W-1:0] CH_4       = 8'h34;
    localparam logic [BYTE_W-1:0] CH_5       = 8'h35;
    localparam logic [BYTE_W-1:0] CH_9       = 8'h39;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  held_digit;
        logic [CODE_W-1:0]  pending_fg;
        logic [CODE_W-1:0]  pending_bg;
        logic [RGB_W-1:0]   display_fg;
        logic [RGB_W-1:0]   display_bg;
    } t_parse_state;

    typedef struct packed {
        logic [RGB_W-1:0] default_fg;
        logic [RGB_W-1:0] default_bg;
    } t_defaults;

    typedef struct packed {
        t_parse_state state;
        logic         clear;
        logic         applied;
    } t_step_result;

    // fixed color table, other codes select the default register
    function automatic logic [RGB_W-1:0] code_to_rgb(
        input logic [CODE_W-1:0] code,
        input logic [RGB_W-1:0]  dflt
    );
        logic [RGB_W-1:0] rgb;
        case (code)
            3'd0:    rgb = 24'h000000;
            3'd1:    rgb = 24'hFF0000;
            3'd2:    rgb = 24'h50C878;
            3'd3:    rgb = 24'hFFD700;
            3'd4:    rgb = 24'h6495ED;
            3'd5:    rgb = 24'hFF00FF;
            default: rgb = dflt;
        endcase
        return rgb;
    endfunction

endpackage

### rtl/acep_byte_if.sv
// ----------------------------------------------------------------------------
// acep_byte_if
// Byte stream channel into the escape sequence parser.
// ----------------------------------------------------------------------------
interface acep_byte_if;
    logic                        valid;
    logic                        ready;
    logic [acep_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

### rtl/acep_color_if.sv
// ----------------------------------------------------------------------------
// acep_color_if
// Result channel carrying shown colors and event flags.
// ----------------------------------------------------------------------------
interface acep_color_if;
    logic                       valid;
    logic                       ready;
    logic [acep_pkg::RGB_W-1:0] shown_fg_rgb;
    logic [acep_pkg::RGB_W-1:0] shown_bg_rgb;
    logic                       clear_request;
    logic                       color_applied;

    modport source (output valid, output shown_fg_rgb, output shown_bg_rgb,
                    output clear_request, output color_applied, input ready);
    modport sink   (input valid, input shown_fg_rgb, input shown_bg_rgb,
                    input clear_request, input color_applied, output ready);
endinterface

### rtl/ansi_color_escape_parser_unit.sv
// ----------------------------------------------------------------------------
// ansi_color_escape_parser_unit
// Terminal byte parser for clear-screen and SGR color escape sequences.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       payload
//  i_in      in    valid/ready     in_byte[7:0]
//  o_out     out   valid/ready     shown_fg_rgb, shown_bg_rgb, clear_request,
//                                  color_applied
//  i_cfg_*   in    write enable    index[0], data[23:0], no read-back
//
//  one byte per cycle unless stalled: a byte transfer updates the parse state
//  and loads the result register at the same edge; the result is valid next cycle
//  the result register acts as the output stage: a new byte is taken while it
//  is empty or while its contents transfer out in the same cycle
//  a stalled output holds both the result and the input (ready drops)
//  synchronous active-low reset: idle phase, no pending codes, default colors
//
module ansi_color_escape_parser_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [acep_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [acep_pkg::RGB_W-1:0]           i_cfg_data,
    acep_byte_if.sink                            i_in,
    acep_color_if.source                         o_out
);

    // default color registers
    acep_pkg::t_defaults    r_defaults;

    // parse state, including the shown colors
    acep_pkg::t_parse_state r_state;

    // result register
    logic                          r_out_valid;
    logic [acep_pkg::RGB_W-1:0]    r_out_fg;
    logic [acep_pkg::RGB_W-1:0]    r_out_bg;
    logic                          r_out_clear;
    logic                          r_out_applied;

    acep_pkg::t_step_result w_step;
    logic                   w_in_xfer;
    logic                   w_out_xfer;

    // room in the result register when it is empty or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = r_out_valid && o_out.ready;

    acep_step u_step (
        .i_state    (r_state),
        .i_defaults (r_defaults),
        .i_byte     (i_in.in_byte),
        .o_result   (w_step)
    );

    // configuration writes; the one-bit index selects either default register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defaults.default_fg <= acep_pkg::DEFAULT_FG_RESET;
            r_defaults.default_bg <= acep_pkg::DEFAULT_BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acep_pkg::CFG_DEFAULT_FG: r_defaults.default_fg <= i_cfg_data;
                acep_pkg::CFG_DEFAULT_BG: r_defaults.default_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parse state advances on every byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= acep_pkg::PH_IDLE;
            r_state.held_digit <= '0;
            r_state.pending_fg <= acep_pkg::CODE_NONE;
            r_state.pending_bg <= acep_pkg::CODE_NONE;
            r_state.display_fg <= acep_pkg::DEFAULT_FG_RESET;
            r_state.display_bg <= acep_pkg::DEFAULT_BG_RESET;
        end else if (w_in_xfer) begin
            r_state <= w_step.state;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, colors taken after the update
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_fg      <= w_step.state.display_fg;
            r_out_bg      <= w_step.state.display_bg;
            r_out_clear   <= w_step.clear;
            r_out_applied <= w_step.applied;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.shown_fg_rgb  = r_out_fg;
    assign o_out.shown_bg_rgb  = r_out_bg;
    assign o_out.clear_request = r_out_clear;
    assign o_out.color_applied = r_out_applied;

    // a byte transfer always leaves a result behind
    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_out_valid)
        else $error("byte transfer did not produce a result");

    // a clear only completes from the digit phase
    a_clear_from_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_step.clear) |-> (r_state.phase == acep_pkg::PH_DIGIT))
        else $error("clear outside digit phase");

    // one byte never both clears and applies a color
    a_clear_apply_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_clear && r_out_applied))
        else $error("clear and color apply on the same byte");

    // shown colors change only on an applying byte
    a_colors_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && !w_step.applied) |=>
            ($stable(r_state.display_fg) && $stable(r_state.display_bg)))
        else $error("shown colors changed without apply");

    // an applied color leaves both pending codes set
    a_apply_needs_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_step.applied) |=>
            (r_state.pending_fg != acep_pkg::CODE_NONE &&
             r_state.pending_bg != acep_pkg::CODE_NONE))
        else $error("color applied with a missing pending code");

endmodule

### rtl/acep_step.sv
// ----------------------------------------------------------------------------
// acep_step
// Next-state logic of the parser for one byte.
// ----------------------------------------------------------------------------
module acep_step (
    input  acep_pkg::t_parse_state       i_state,
    input  acep_pkg::t_defaults          i_defaults,
    input  logic [acep_pkg::BYTE_W-1:0]  i_byte,
    output acep_pkg::t_step_result       o_result
);

    acep_pkg::t_parse_state n_state;
    logic                   w_try;
    logic                   w_clear;
    logic                   w_applied;
    logic                   w_is_digit;
    logic                   w_is_code;

    assign w_is_digit = (i_byte inside {[acep_pkg::CH_0:acep_pkg::CH_9]});
    assign w_is_code  = (i_byte inside {[acep_pkg::CH_0:acep_pkg::CH_5]});

    always_comb begin
        n_state   = i_state;
        w_try     = 1'b0;
        w_clear   = 1'b0;
        w_applied = 1'b0;
        case (i_state.phase)
            acep_pkg::PH_ESC: begin
                n_state.phase = (i_byte == acep_pkg::CH_LBRACK) ?
                                acep_pkg::PH_BRACKET : acep_pkg::PH_IDLE;
            end
            acep_pkg::PH_BRACKET: begin
                if (w_is_digit) begin
                    n_state.phase      = acep_pkg::PH_DIGIT;
                    n_state.held_digit = i_byte;
                end else begin
                    n_state.phase = acep_pkg::PH_IDLE;
                end
            end
            acep_pkg::PH_DIGIT: begin
                if (i_state.held_digit == acep_pkg::CH_2 && i_byte == acep_pkg::CH_UPPER_J) begin
                    w_clear       = 1'b1;
                    n_state.phase = acep_pkg::PH_IDLE;
                end else if (i_state.held_digit == acep_pkg::CH_0 &&
                             i_byte == acep_pkg::CH_LOWER_M) begin
                    n_state.pending_fg = acep_pkg::CODE_RESET;
                    n_state.pending_bg = acep_pkg::CODE_RESET;
                    w_try              = 1'b1;
                    n_state.phase      = acep_pkg::PH_IDLE;
                end else if (i_state.held_digit == acep_pkg::CH_3 && w_is_code) begin
                    // '0'..'5' map to codes through their low bits
                    n_state.pending_fg = i_byte[acep_pkg::CODE_W-1:0];
                end else if (i_byte == acep_pkg::CH_SEMI) begin
                    n_state.phase      = acep_pkg::PH_BACKGROUND;
                    n_state.held_digit = '0;
                end else if (i_byte == acep_pkg::CH_LOWER_M) begin
                    // bare terminator resets the background
                    n_state.pending_bg = acep_pkg::CODE_RESET;
                    w_try              = 1'b1;
                    n_state.phase      = acep_pkg::PH_IDLE;
                end else begin
                    n_state.phase = acep_pkg::PH_IDLE;
                end
            end
            acep_pkg::PH_BACKGROUND: begin
                if (i_state.held_digit == '0 && w_is_digit) begin
                    n_state.held_digit = i_byte;
                end else if (i_state.held_digit == acep_pkg::CH_4 && w_is_code) begin
                    n_state.pending_bg = i_byte[acep_pkg::CODE_W-1:0];
                end else if (i_byte == acep_pkg::CH_LOWER_M) begin
                    w_try         = 1'b1;
                    n_state.phase = acep_pkg::PH_IDLE;
                end else begin
                    n_state.phase = acep_pkg::PH_IDLE;
                end
            end
            default: begin
                n_state.phase = (i_byte == acep_pkg::CH_ESC) ?
                                acep_pkg::PH_ESC : acep_pkg::PH_IDLE;
            end
        endcase

        // apply only when both pending codes are set
        if (w_try && n_state.pending_fg != acep_pkg::CODE_NONE &&
            n_state.pending_bg != acep_pkg::CODE_NONE) begin
            w_applied          = 1'b1;
            n_state.display_fg = acep_pkg::code_to_rgb(n_state.pending_fg,
                                                       i_defaults.default_fg);
            n_state.display_bg = acep_pkg::code_to_rgb(n_state.pending_bg,
                                                       i_defaults.default_bg);
        end
    end

    assign o_result.state   = n_state;
    assign o_result.clear   = w_clear;
    assign o_result.applied = w_applied;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape sequence parser. Byte transfers are
// mirrored by a behavioral tracker of the parse state and shown colors; each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_BYTES = 120;
    localparam int unsigned NUM_PHASES  = 6;

    // fixed six-entry color palette
    localparam logic [acep_pkg::RGB_W-1:0] PALETTE [6] = '{
        24'h000000, 24'hFF0000, 24'h50C878, 24'hFFD700, 24'h6495ED, 24'hFF00FF
    };

    typedef struct {
        logic [acep_pkg::RGB_W-1:0] fg;
        logic [acep_pkg::RGB_W-1:0] bg;
        logic                       clr;
        logic                       app;
    } t_shown;

    // tracks parser state, predicts the shown colors and checks the results
    class sgr_tracker;
        logic [acep_pkg::PHASE_W-1:0] phase;
        logic [acep_pkg::BYTE_W-1:0]  held;
        logic [acep_pkg::CODE_W-1:0]  pend_fg;
        logic [acep_pkg::CODE_W-1:0]  pend_bg;
        logic [acep_pkg::RGB_W-1:0]   disp_fg;
        logic [acep_pkg::RGB_W-1:0]   disp_bg;
        logic [acep_pkg::RGB_W-1:0]   dflt_fg;
        logic [acep_pkg::RGB_W-1:0]   dflt_bg;
        t_shown                       awaited_colors[$];
        int unsigned                  mismatches;

        function new();
            phase      = acep_pkg::PH_IDLE;
            held       = '0;
            pend_fg    = acep_pkg::CODE_NONE;
            pend_bg    = acep_pkg::CODE_NONE;
            dflt_fg    = acep_pkg::DEFAULT_FG_RESET;
            dflt_bg    = acep_pkg::DEFAULT_BG_RESET;
            disp_fg    = dflt_fg;
            disp_bg    = dflt_bg;
            mismatches = 0;
        endfunction

        function void set_default(logic [acep_pkg::CFG_IDX_W-1:0] idx,
                                  logic [acep_pkg::RGB_W-1:0] rgb);
            if (idx == acep_pkg::CFG_DEFAULT_FG) dflt_fg = rgb;
            else                                 dflt_bg = rgb;
        endfunction

        // load shown colors only when both codes are set
        function logic load_colors();
            if (pend_fg == acep_pkg::CODE_NONE || pend_bg == acep_pkg::CODE_NONE)
                return 1'b0;
            disp_fg = (pend_fg < 3'd6) ? PALETTE[pend_fg] : dflt_fg;
            disp_bg = (pend_bg < 3'd6) ? PALETTE[pend_bg] : dflt_bg;
            return 1'b1;
        endfunction

        function void note_byte(logic [acep_pkg::BYTE_W-1:0] c);
            t_shown exp;
            logic   is_num;
            logic   is_code;
            is_num  = (c >= acep_pkg::CH_0) && (c <= acep_pkg::CH_9);
            is_code = (c >= acep_pkg::CH_0) && (c <= acep_pkg::CH_5);
            exp.clr = 1'b0;
            exp.app = 1'b0;
            case (phase)
                acep_pkg::PH_ESC: begin
                    phase = (c == acep_pkg::CH_LBRACK) ?
                            acep_pkg::PH_BRACKET : acep_pkg::PH_IDLE;
                end
                acep_pkg::PH_BRACKET: begin
                    if (is_num) begin
                        phase = acep_pkg::PH_DIGIT;
                        held  = c;
                    end else begin
                        phase = acep_pkg::PH_IDLE;
                    end
                end
                acep_pkg::PH_DIGIT: begin
                    if (held == acep_pkg::CH_2 && c == acep_pkg::CH_UPPER_J) begin
                        exp.clr = 1'b1;
                        phase   = acep_pkg::PH_IDLE;
                    end else if (held == acep_pkg::CH_0 && c == acep_pkg::CH_LOWER_M) begin
                        pend_fg = acep_pkg::CODE_RESET;
                        pend_bg = acep_pkg::CODE_RESET;
                        exp.app = load_colors();
                        phase   = acep_pkg::PH_IDLE;
                    end else if (held == acep_pkg::CH_3 && is_code) begin
                        pend_fg = acep_pkg::CODE_W'(c - acep_pkg::CH_0);
                    end else if (c == acep_pkg::CH_SEMI) begin
                        phase = acep_pkg::PH_BACKGROUND;
                        held  = '0;
                    end else if (c == acep_pkg::CH_LOWER_M) begin
                        pend_bg = acep_pkg::CODE_RESET;
                        exp.app = load_colors();
                        phase   = acep_pkg::PH_IDLE;
                    end else begin
                        phase = acep_pkg::PH_IDLE;
                    end
                end
                acep_pkg::PH_BACKGROUND: begin
                    if (held == '0 && is_num) begin
                        held = c;
                    end else if (held == acep_pkg::CH_4 && is_code) begin
                        pend_bg = acep_pkg::CODE_W'(c - acep_pkg::CH_0);
                    end else if (c == acep_pkg::CH_LOWER_M) begin
                        exp.app = load_colors();
                        phase   = acep_pkg::PH_IDLE;
                    end else begin
                        phase = acep_pkg::PH_IDLE;
                    end
                end
                default: begin
                    phase = (c == acep_pkg::CH_ESC) ?
                            acep_pkg::PH_ESC : acep_pkg::PH_IDLE;
                end
            endcase
            exp.fg = disp_fg;
            exp.bg = disp_bg;
            awaited_colors.push_back(exp);
        endfunction

        function void compare_field(string name, logic [acep_pkg::RGB_W-1:0] exp_v,
                                    logic [acep_pkg::RGB_W-1:0] got_v);
            if (exp_v !== got_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on %s: expected %h, got %h", name, exp_v, got_v);
            end
        endfunction

        function void check_color(t_shown got);
            t_shown exp;
            if (awaited_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: fg %h bg %h clear %b applied %b",
                             got.fg, got.bg, got.clr, got.app);
                return;
            end
            exp = awaited_colors.pop_front();
            compare_field("shown_fg_rgb", exp.fg, got.fg);
            compare_field("shown_bg_rgb", exp.bg, got.bg);
            compare_field("clear_request", acep_pkg::RGB_W'(exp.clr),
                          acep_pkg::RGB_W'(got.clr));
            compare_field("color_applied", acep_pkg::RGB_W'(exp.app),
                          acep_pkg::RGB_W'(got.app));
        endfunction

        function int unsigned outstanding();
            return awaited_colors.size();
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [acep_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [acep_pkg::RGB_W-1:0]     i_cfg_data;

    acep_byte_if  in_ch ();
    acep_color_if out_ch ();

    ansi_color_escape_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    sgr_tracker  tracker;
    bit          idle_en = 1'b1;   // random gaps and stalls, off for the final phase
    int unsigned bytes_sent = 0;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;

    // 20 time unit clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check each transfer, then pick ready for the next edge
    // random stall bursts while idling is enabled
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tracker.check_color('{out_ch.shown_fg_rgb, out_ch.shown_bg_rgb,
                                   out_ch.clear_request, out_ch.color_applied});
        if (!idle_en) begin
            stall_left    <= 0;
            out_ch.ready  <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            out_ch.ready  <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left    <= $urandom_range(0, 2);
            out_ch.ready  <= 1'b0;
        end else begin
            out_ch.ready  <= 1'b1;
        end
    end

    // one byte transfer, with an optional random gap ahead of it
    // valid stays high between back-to-back bytes
    task automatic send_byte(input logic [acep_pkg::BYTE_W-1:0] b);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    // drop valid and wait until every predicted result has been checked
    // the pause afterwards covers the result register stage
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register write, only called while the parser is idle
    task automatic write_reg(input logic [acep_pkg::CFG_IDX_W-1:0] idx,
                             input logic [acep_pkg::RGB_W-1:0] rgb);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= rgb;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_default(idx, rgb);
    endtask

    function automatic logic [acep_pkg::BYTE_W-1:0] code_digit();
        return acep_pkg::CH_0 + acep_pkg::BYTE_W'($urandom_range(0, 5));
    endfunction

    function automatic logic [acep_pkg::BYTE_W-1:0] any_digit();
        return acep_pkg::CH_0 + acep_pkg::BYTE_W'($urandom_range(0, 9));
    endfunction

    // byte that tends to matter somewhere in a sequence
    function automatic logic [acep_pkg::BYTE_W-1:0] near_miss_byte();
        case ($urandom_range(0, 7))
            0:       return acep_pkg::CH_LBRACK;
            1:       return acep_pkg::CH_SEMI;
            2:       return acep_pkg::CH_LOWER_M;
            3:       return acep_pkg::CH_UPPER_J;
            4:       return acep_pkg::CH_ESC;
            5, 6:    return any_digit();
            default: return acep_pkg::BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed sequences with random content, some noise and
    // broken sequences mixed in
    task automatic send_random_sequence();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            // plain text / noise
            repeat ($urandom_range(1, 3))
                send_byte(acep_pkg::BYTE_W'($urandom_range(0, 255)));
        end else if (kind < 20) begin
            // clear screen
            send_byte(acep_pkg::CH_ESC);
            send_byte(acep_pkg::CH_LBRACK);
            send_byte(acep_pkg::CH_2);
            send_byte(acep_pkg::CH_UPPER_J);
        end else if (kind < 30) begin
            // color reset
            send_byte(acep_pkg::CH_ESC);
            send_byte(acep_pkg::CH_LBRACK);
            send_byte(acep_pkg::CH_0);
            send_byte(acep_pkg::CH_LOWER_M);
        end else if (kind < 80) begin
            // foreground, optional background, terminator
            send_byte(acep_pkg::CH_ESC);
            send_byte(acep_pkg::CH_LBRACK);
            send_byte(($urandom_range(0, 5) == 0) ? any_digit() : acep_pkg::CH_3);
            n = $urandom_range(0, 2);
            repeat (n) send_byte(code_digit());
            if ($urandom_range(0, 2) != 0) begin
                send_byte(acep_pkg::CH_SEMI);
                if ($urandom_range(0, 5) != 0) begin
                    send_byte(($urandom_range(0, 5) == 0) ? any_digit() : acep_pkg::CH_4);
                    n = $urandom_range(0, 2);
                    repeat (n) send_byte(code_digit());
                end
            end
            send_byte(($urandom_range(0, 9) == 0) ? near_miss_byte() :
                      acep_pkg::CH_LOWER_M);
        end else begin
            // broken sequence
            send_byte(acep_pkg::CH_ESC);
            repeat ($urandom_range(1, 4)) send_byte(near_miss_byte());
        end
    endtask

    // directed bytes: incomplete codes, repeated digits, clear, color reset,
    // byte extremes, persisting pending codes after a non-color digit
    localparam logic [acep_pkg::BYTE_W-1:0] DIRECTED [28] = '{
        acep_pkg::CH_ESC, acep_pkg::CH_LBRACK, acep_pkg::CH_3, acep_pkg::CH_LOWER_M,
        acep_pkg::CH_ESC, acep_pkg::CH_LBRACK, acep_pkg::CH_3, acep_pkg::CH_0,
        acep_pkg::CH_5, acep_pkg::CH_SEMI, acep_pkg::CH_4, acep_pkg::CH_2,
        acep_pkg::CH_LOWER_M,
        acep_pkg::CH_ESC, acep_pkg::CH_LBRACK, acep_pkg::CH_2, acep_pkg::CH_UPPER_J,
        acep_pkg::CH_ESC, acep_pkg::CH_LBRACK, acep_pkg::CH_0, acep_pkg::CH_LOWER_M,
        8'h00, 8'hFF,
        acep_pkg::CH_ESC, acep_pkg::CH_LBRACK, acep_pkg::CH_9, acep_pkg::CH_SEMI,
        acep_pkg::CH_LOWER_M
    };

    initial begin
        logic [acep_pkg::RGB_W-1:0] fg_val;
        logic [acep_pkg::RGB_W-1:0] bg_val;
        int unsigned                phase_start;

        tracker        = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= acep_pkg::CFG_DEFAULT_FG;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs on the reset defaults
        foreach (DIRECTED[k]) send_byte(DIRECTED[k]);
        settle();

        // random phases, each with its own default colors
        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       begin fg_val = 24'h000000; bg_val = 24'hFFFFFF; end
                2:       begin fg_val = 24'hFFFFFF; bg_val = 24'hFFFFFF; end
                3:       begin fg_val = 24'h000000; bg_val = 24'h000000; end
                default: begin
                    fg_val = acep_pkg::RGB_W'($urandom);
                    bg_val = acep_pkg::RGB_W'($urandom);
                end
            endcase
            write_reg(acep_pkg::CFG_DEFAULT_FG, fg_val);
            write_reg(acep_pkg::CFG_DEFAULT_BG, bg_val);

            // last phase at full rate on both sides
            if (ph == NUM_PHASES - 1) idle_en = 1'b0;

            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) send_random_sequence();
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
